@@ rtl/overlap_repulsion_accumulate_defines.svh @@
// ---------------------------------------------------------------------------
// overlap_repulsion_accumulate assertion macros
// Concurrent check wrappers, empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef OVERLAP_REPULSION_ACCUMULATE_DEFINES_SVH
`define OVERLAP_REPULSION_ACCUMULATE_DEFINES_SVH

`ifndef SYNTHESIS
`define ORC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("check failed");
`define ORC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define ORC_ASSERT(lbl, clk, rst_n, prop)
`define ORC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/orc_pkg.sv @@
// ---------------------------------------------------------------------------
// orc_pkg
// Widths, constants and the queue entry type of the overlap accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package orc_pkg;

    localparam int POS_W      = 24;
    localparam int RAD_W      = 20;
    localparam int ACC_W      = 32;
    localparam int DELTA_W    = POS_W + 1;
    localparam int RS_W       = RAD_W + 1;
    localparam int SQ_W       = 2 * POS_W;
    localparam int SSUM_W     = SQ_W + 2;
    localparam int S_W        = 2 * RS_W;
    localparam int ROOT_W     = RS_W;
    localparam int SQREM_W    = ROOT_W + 2;
    localparam int QUOT_W     = ROOT_W + 1;
    localparam int DIV_W      = ROOT_W + 1;
    localparam int PROD_W     = POS_W + RS_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int CONTRIB_W  = QUOT_W + 1;
    localparam int CNT_W      = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-3:0] REG_OWN_X      = 2'd0;
    localparam logic [APB_ADDR_W-3:0] REG_OWN_Y      = 2'd1;
    localparam logic [APB_ADDR_W-3:0] REG_OWN_Z      = 2'd2;
    localparam logic [APB_ADDR_W-3:0] REG_OWN_RADIUS = 2'd3;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [DELTA_W-1:0] dz;
        logic [S_W-1:0]            s;
        logic [RS_W-1:0]           rs;
        logic                      hit;
        logic                      last;
    } orc_entry_t;

    function automatic logic [POS_W-1:0] orc_mag(input logic signed [DELTA_W-1:0] v);
        logic [DELTA_W-1:0] a;
        a = v[DELTA_W-1] ? (~v + 1'b1) : v;
        return a[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/orc_front.sv @@
// ---------------------------------------------------------------------------
// orc_front
// Takes neighbor transfers, squares the offsets and flags overlapping pairs.
// ---------------------------------------------------------------------------
`default_nettype none

module orc_front #(
    parameter int DEPTH = orc_pkg::FIFO_DEPTH
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire  [orc_pkg::POS_W-1:0]         own_x,
    input  wire  [orc_pkg::POS_W-1:0]         own_y,
    input  wire  [orc_pkg::POS_W-1:0]         own_z,
    input  wire  [orc_pkg::RAD_W-1:0]         own_radius,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire  [orc_pkg::POS_W-1:0]         nbr_x,
    input  wire  [orc_pkg::POS_W-1:0]         nbr_y,
    input  wire  [orc_pkg::POS_W-1:0]         nbr_z,
    input  wire  [orc_pkg::RAD_W-1:0]         nbr_radius,
    input  wire                               skip_entry,
    input  wire                               last_entry,
    input  wire  [$clog2(DEPTH+1)-1:0]        fifo_level,
    output logic                              push,
    output orc_pkg::orc_entry_t               push_entry
);
    import orc_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);

    logic                      v1_reg, v2_reg;
    logic signed [DELTA_W-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [DELTA_W-1:0] dx2_reg, dy2_reg, dz2_reg;
    logic [RS_W-1:0]           rs1_reg, rs2_reg;
    logic                      skip1_reg, skip2_reg, last1_reg, last2_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg, sqz_reg;
    logic [S_W-1:0]            rsq_reg;
    logic [LW:0]               used;
    logic                      accept;
    logic [SSUM_W-1:0]         ssum;

    // credit check: everything in flight must fit in the queue
    assign used     = {1'b0, fifo_level} + (LW+1)'(v1_reg) + (LW+1)'(v2_reg);
    assign in_stall = (used >= (LW+1)'(DEPTH));
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx1_reg   <= $signed({1'b0, own_x}) - $signed({1'b0, nbr_x});
            dy1_reg   <= $signed({1'b0, own_y}) - $signed({1'b0, nbr_y});
            dz1_reg   <= $signed({1'b0, own_z}) - $signed({1'b0, nbr_z});
            rs1_reg   <= {1'b0, own_radius} + {1'b0, nbr_radius};
            skip1_reg <= skip_entry;
            last1_reg <= last_entry;
        end
        if (v1_reg)
        begin
            sqx_reg   <= orc_mag(dx1_reg) * orc_mag(dx1_reg);
            sqy_reg   <= orc_mag(dy1_reg) * orc_mag(dy1_reg);
            sqz_reg   <= orc_mag(dz1_reg) * orc_mag(dz1_reg);
            rsq_reg   <= rs1_reg * rs1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            dz2_reg   <= dz1_reg;
            rs2_reg   <= rs1_reg;
            skip2_reg <= skip1_reg;
            last2_reg <= last1_reg;
        end
    end

    assign ssum = SSUM_W'(sqx_reg) + SSUM_W'(sqy_reg) + SSUM_W'(sqz_reg);

    always_comb
    begin
        push            = v2_reg;
        push_entry.dx   = dx2_reg;
        push_entry.dy   = dy2_reg;
        push_entry.dz   = dz2_reg;
        push_entry.s    = ssum[S_W-1:0];
        push_entry.rs   = rs2_reg;
        push_entry.hit  = !skip2_reg && (ssum != '0) && (ssum < SSUM_W'(rsq_reg));
        push_entry.last = last2_reg;
    end

endmodule

`default_nettype wire

@@ rtl/orc_fifo.sv @@
// ---------------------------------------------------------------------------
// orc_fifo
// Short queue of classified neighbor entries between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "overlap_repulsion_accumulate_defines.svh"

module orc_fifo #(
    parameter int DEPTH = orc_pkg::FIFO_DEPTH
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               push,
    input  orc_pkg::orc_entry_t               push_entry,
    input  wire                               pop,
    output orc_pkg::orc_entry_t               head,
    output logic                              empty,
    output logic [$clog2(DEPTH+1)-1:0]        level
);
    import orc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    orc_entry_t     mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]  level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

    `ORC_ASSERT(a_no_overflow, clk, rst_n, !(push && !pop && level_reg == LW'(DEPTH)))
    `ORC_ASSERT(a_no_underflow, clk, rst_n, !(pop && level_reg == '0))

endmodule

`default_nettype wire

@@ rtl/orc_back.sv @@
// ---------------------------------------------------------------------------
// orc_back
// Square root, scaling divide and saturating accumulation per entry.
// ---------------------------------------------------------------------------
`default_nettype none
`include "overlap_repulsion_accumulate_defines.svh"

module orc_back (
    input  wire                               clk,
    input  wire                               rst_n,
    input  orc_pkg::orc_entry_t               head,
    input  wire                               empty,
    output logic                              pop,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic signed [orc_pkg::ACC_W-1:0]  push_x,
    output logic signed [orc_pkg::ACC_W-1:0]  push_y,
    output logic signed [orc_pkg::ACC_W-1:0]  push_z
);
    import orc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQRT = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_ACC  = 5'b10000
    } back_state_t;

    back_state_t               state_reg, state_next;
    orc_entry_t                ent_reg;
    logic [S_W-1:0]            s_sh_reg;
    logic [SQREM_W-1:0]        sq_rem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [DIV_W-1:0]          drem_reg [3];
    logic [QUOT_W-1:0]         quo_reg  [3];
    logic signed [ACC_W-1:0]   sum_reg  [3];
    logic signed [ACC_W-1:0]   sum_new  [3];
    logic                      out_valid_reg;
    logic signed [ACC_W-1:0]   out_reg  [3];

    logic [SQREM_W+1:0]        sq_shift;
    logic [SQREM_W+1:0]        sq_trial;
    logic                      sq_take;
    logic [RS_W-1:0]           ov;
    logic [DIV_W-1:0]          dvsr;
    logic signed [DELTA_W-1:0] delta [3];
    logic [NUM_W-1:0]          num   [3];
    logic [DIV_W:0]            dshift [3];
    logic                      dtake  [3];
    logic signed [CONTRIB_W-1:0] contrib [3];
    logic signed [ACC_W:0]     wide  [3];
    logic                      out_free;
    logic                      acc_done;

    assign delta[0] = ent_reg.dx;
    assign delta[1] = ent_reg.dy;
    assign delta[2] = ent_reg.dz;

    // one result bit per cycle, two radicand bits brought down each step
    assign sq_shift = {sq_rem_reg, s_sh_reg[S_W-1 -: 2]};
    assign sq_trial = (SQREM_W+2)'({root_reg, 2'b01});
    assign sq_take  = (sq_shift >= sq_trial);

    assign ov   = ent_reg.rs - root_reg;
    assign dvsr = {root_reg, 1'b0};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num[k]    = NUM_W'(orc_mag(delta[k])) * NUM_W'(ov) + NUM_W'(root_reg);
            dshift[k] = {drem_reg[k], quo_reg[k][QUOT_W-1]};
            dtake[k]  = (dshift[k] >= {1'b0, dvsr});
            contrib[k] = '0;
            if (ent_reg.hit)
            begin
                contrib[k] = delta[k][DELTA_W-1] ? -$signed({1'b0, quo_reg[k]})
                                                 : $signed({1'b0, quo_reg[k]});
            end
            wide[k] = {sum_reg[k][ACC_W-1], sum_reg[k]} + (ACC_W+1)'(contrib[k]);
            if (wide[k][ACC_W] != wide[k][ACC_W-1])
            begin
                sum_new[k] = wide[k][ACC_W] ? ACC_MIN : ACC_MAX;
            end
            else
            begin
                sum_new[k] = wide[k][ACC_W-1:0];
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign acc_done = (state_reg == ST_ACC) && (!ent_reg.last || out_free);
    assign pop      = (state_reg == ST_IDLE) && !empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = head.hit ? ST_SQRT : ST_ACC;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == CNT_W'(ROOT_W-1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(QUOT_W-1))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (acc_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
            if (acc_done)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sum_reg[k] <= ent_reg.last ? '0 : sum_new[k];
                end
                if (ent_reg.last)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg    <= head;
            s_sh_reg   <= head.s;
            sq_rem_reg <= '0;
            root_reg   <= '0;
            cnt_reg    <= '0;
        end
        case (state_reg)
            ST_SQRT:
            begin
                s_sh_reg   <= {s_sh_reg[S_W-3:0], 2'b00};
                sq_rem_reg <= sq_take ? SQREM_W'(sq_shift - sq_trial)
                                      : SQREM_W'(sq_shift);
                root_reg   <= {root_reg[ROOT_W-2:0], sq_take};
                cnt_reg    <= cnt_reg + 1'b1;
            end
            ST_MUL:
            begin
                cnt_reg <= '0;
                // quotient fits QUOT_W bits, so the upper part is below the divisor
                for (int k = 0; k < 3; k++)
                begin
                    drem_reg[k] <= num[k][QUOT_W +: DIV_W];
                    quo_reg[k]  <= num[k][QUOT_W-1:0];
                end
            end
            ST_DIV:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                for (int k = 0; k < 3; k++)
                begin
                    drem_reg[k] <= dtake[k] ? DIV_W'(dshift[k] - {1'b0, dvsr})
                                            : DIV_W'(dshift[k]);
                    quo_reg[k]  <= {quo_reg[k][QUOT_W-2:0], dtake[k]};
                end
            end
            default:
            begin
            end
        endcase
        if (acc_done && ent_reg.last)
        begin
            for (int k = 0; k < 3; k++)
            begin
                out_reg[k] <= sum_new[k];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign push_x    = out_reg[0];
    assign push_y    = out_reg[1];
    assign push_z    = out_reg[2];

    `ORC_ASSERT_NEXT(a_pop_leaves_idle, clk, rst_n, pop, state_reg != ST_IDLE)
    `ORC_ASSERT(a_root_below_sum, clk, rst_n, !(state_reg == ST_MUL) || (root_reg < ent_reg.rs))
    `ORC_ASSERT(a_no_result_drop, clk, rst_n, !(acc_done && ent_reg.last && out_valid_reg && out_stall))

endmodule

`default_nettype wire

@@ rtl/overlap_repulsion_accumulate.sv @@
// ---------------------------------------------------------------------------
// overlap_repulsion_accumulate
// Soft-sphere overlap push summed over a stream of neighbors of one cell.
// ---------------------------------------------------------------------------
// The front end takes one neighbor transfer per cycle while the queue has
// room and flags pairs closer than their radius sum. The back end then works
// on one entry at a time: a non-overlapping or skipped entry goes straight
// from idle to accumulate, an overlapping one through a 21-step square root,
// one multiply, 22-step divide shared by the three axes in lockstep and one
// accumulate. Sustained rate is therefore set by the back end's root and
// divide iterations. A transfer marked last yields one result with the sums,
// held in an output register while the back end moves on to the next entry.
`default_nettype none

module overlap_repulsion_accumulate #(
    parameter int DEPTH = orc_pkg::FIFO_DEPTH
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [orc_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire  [orc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [orc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire  [orc_pkg::POS_W-1:0]            nbr_x,
    input  wire  [orc_pkg::POS_W-1:0]            nbr_y,
    input  wire  [orc_pkg::POS_W-1:0]            nbr_z,
    input  wire  [orc_pkg::RAD_W-1:0]            nbr_radius,
    input  wire                                  skip_entry,
    input  wire                                  last_entry,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic signed [orc_pkg::ACC_W-1:0]     push_x,
    output logic signed [orc_pkg::ACC_W-1:0]     push_y,
    output logic signed [orc_pkg::ACC_W-1:0]     push_z
);
    import orc_pkg::*;

    logic [POS_W-1:0]            own_x_reg, own_y_reg, own_z_reg;
    logic [RAD_W-1:0]            own_radius_reg;
    logic [APB_ADDR_W-3:0]       reg_idx;
    logic                        wr_en;
    logic                        push, pop, empty;
    orc_entry_t                  push_entry, head;
    logic [$clog2(DEPTH+1)-1:0]  level;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_x_reg      <= '0;
            own_y_reg      <= '0;
            own_z_reg      <= '0;
            own_radius_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_OWN_X:      own_x_reg      <= pwdata[POS_W-1:0];
                REG_OWN_Y:      own_y_reg      <= pwdata[POS_W-1:0];
                REG_OWN_Z:      own_z_reg      <= pwdata[POS_W-1:0];
                REG_OWN_RADIUS: own_radius_reg <= pwdata[RAD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_OWN_X:      prdata = APB_DATA_W'(own_x_reg);
            REG_OWN_Y:      prdata = APB_DATA_W'(own_y_reg);
            REG_OWN_Z:      prdata = APB_DATA_W'(own_z_reg);
            REG_OWN_RADIUS: prdata = APB_DATA_W'(own_radius_reg);
            default:        prdata = '0;
        endcase
    end

    orc_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .own_x      (own_x_reg),
        .own_y      (own_y_reg),
        .own_z      (own_z_reg),
        .own_radius (own_radius_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .nbr_x      (nbr_x),
        .nbr_y      (nbr_y),
        .nbr_z      (nbr_z),
        .nbr_radius (nbr_radius),
        .skip_entry (skip_entry),
        .last_entry (last_entry),
        .fifo_level (level),
        .push       (push),
        .push_entry (push_entry)
    );

    orc_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .level      (level)
    );

    orc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .push_x    (push_x),
        .push_y    (push_y),
        .push_z    (push_z)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ---------------------------------------------------------------------------
// overlap_repulsion_accumulate testbench
// Streams neighbor sets at the accumulator through its handshake and
// reprograms the cell through the register port between phases. A scoreboard
// predicts each summed push vector and compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import orc_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic [RAD_W-1:0] r;
        logic             skip;
        logic             last;
    } nbr_t;

    typedef struct {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
    } push_t;

    class push_scoreboard;
        longint own_x, own_y, own_z, own_r;
        longint sum_x, sum_y, sum_z;
        push_t  expected_q[$];
        int     failures;

        function void set_reg(int idx, logic [31:0] val);
            case (idx)
                REG_OWN_X:      own_x = longint'(val[POS_W-1:0]);
                REG_OWN_Y:      own_y = longint'(val[POS_W-1:0]);
                REG_OWN_Z:      own_z = longint'(val[POS_W-1:0]);
                REG_OWN_RADIUS: own_r = longint'(val[RAD_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint root_floor(longint v);
            longint r;
            longint b;
            r = 0;
            b = longint'(1) << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // half the overlap projected on one axis, rounded half away from zero
        function longint axis_push(longint delta, longint ov, longint d);
            longint mag;
            longint q;
            mag = (delta < 0) ? -delta : delta;
            q = (mag * ov + d) / (2 * d);
            return (delta < 0) ? -q : q;
        endfunction

        function longint clamp_add(longint acc, longint c);
            longint s;
            s = acc + c;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            return s;
        endfunction

        function void note_neighbor(nbr_t n);
            longint dx, dy, dz, s, rs, d, ov;
            push_t  p;
            if (!n.skip) begin
                dx = own_x - longint'(n.x);
                dy = own_y - longint'(n.y);
                dz = own_z - longint'(n.z);
                s  = dx * dx + dy * dy + dz * dz;
                rs = own_r + longint'(n.r);
                if (s != 0 && s < rs * rs) begin
                    d  = root_floor(s);
                    ov = rs - d;
                    sum_x = clamp_add(sum_x, axis_push(dx, ov, d));
                    sum_y = clamp_add(sum_y, axis_push(dy, ov, d));
                    sum_z = clamp_add(sum_z, axis_push(dz, ov, d));
                end
            end
            if (n.last) begin
                p.x = sum_x[31:0];
                p.y = sum_y[31:0];
                p.z = sum_z[31:0];
                expected_q = {expected_q, p};
                sum_x = 0;
                sum_y = 0;
                sum_z = 0;
            end
        endfunction

        function void check_push(push_t got);
            push_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected push x=%0d y=%0d z=%0d", $time,
                         got.x, got.y, got.z);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (got.x !== e.x) begin
                $display("%0t: push_x expected %0d actual %0d", $time, e.x, got.x);
                failures++;
            end
            if (got.y !== e.y) begin
                $display("%0t: push_y expected %0d actual %0d", $time, e.y, got.y);
                failures++;
            end
            if (got.z !== e.z) begin
                $display("%0t: push_z expected %0d actual %0d", $time, e.z, got.z);
                failures++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_stall;
    logic [POS_W-1:0]       nbr_x;
    logic [POS_W-1:0]       nbr_y;
    logic [POS_W-1:0]       nbr_z;
    logic [RAD_W-1:0]       nbr_radius;
    logic                   skip_entry;
    logic                   last_entry;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [ACC_W-1:0] push_x;
    logic signed [ACC_W-1:0] push_y;
    logic signed [ACC_W-1:0] push_z;

    push_scoreboard sb;
    bit             no_idle;
    bit             hold_req;
    logic [POS_W-1:0] cell_x, cell_y, cell_z;

    overlap_repulsion_accumulate u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .nbr_x      (nbr_x),
        .nbr_y      (nbr_y),
        .nbr_z      (nbr_z),
        .nbr_radius (nbr_radius),
        .skip_entry (skip_entry),
        .last_entry (last_entry),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .push_x     (push_x),
        .push_y     (push_y),
        .push_z     (push_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL overlap_repulsion_accumulate");
        $finish;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    // called right after a rising edge; returns right after the transfer edge
    task automatic send_nbr(nbr_t n);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        nbr_x      <= n.x;
        nbr_y      <= n.y;
        nbr_z      <= n.z;
        nbr_radius <= n.r;
        skip_entry <= n.skip;
        last_entry <= n.last;
        do
        begin
            @(negedge clk);
        end while (in_stall);
        @(posedge clk);
        sb.note_neighbor(n);
    endtask

    task automatic reg_write(int idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // wait until every push has come back and the back end has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_cell(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [31:0] r);
        reg_write(REG_OWN_X, x);
        reg_write(REG_OWN_Y, y);
        reg_write(REG_OWN_Z, z);
        reg_write(REG_OWN_RADIUS, r);
        cell_x = x[POS_W-1:0];
        cell_y = y[POS_W-1:0];
        cell_z = z[POS_W-1:0];
    endtask

    function automatic logic [POS_W-1:0] near_coord(logic [POS_W-1:0] c);
        longint v;
        longint off;
        off = longint'($urandom_range(0, (1 << $urandom_range(0, 21))));
        v = $urandom_range(0, 1) ? longint'(c) + off : longint'(c) - off;
        if (v < 0) v = 0;
        if (v > longint'(POS_MAX)) v = POS_MAX;
        return v[POS_W-1:0];
    endfunction

    function automatic nbr_t random_nbr(bit last);
        nbr_t n;
        if ($urandom_range(0, 3) == 0)
        begin
            n.x = POS_W'($urandom);
            n.y = POS_W'($urandom);
            n.z = POS_W'($urandom);
        end
        else
        begin
            n.x = near_coord(cell_x);
            n.y = near_coord(cell_y);
            n.z = near_coord(cell_z);
        end
        n.r    = RAD_W'($urandom);
        n.skip = ($urandom_range(0, 7) == 0);
        n.last = last;
        return n;
    endfunction

    task automatic random_sets(int items);
        int left;
        int len;
        left = items;
        while (left > 0)
        begin
            len = $urandom_range(1, 12);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) send_nbr(random_nbr(i == len - 1));
            left -= len;
        end
    endtask

    // receiver: random stall before each result, one long hold-off on request
    initial
    begin
        int    n;
        bit    got;
        push_t p;
        out_stall = 1'b1;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 14);
            if (hold_req)
            begin
                n = 800;
                hold_req = 1'b0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                got = out_valid;
                p.x = push_x;
                p.y = push_y;
                p.z = push_z;
                @(posedge clk);
            end while (!got);
            sb.check_push(p);
        end
    end

    initial
    begin
        sb = new();
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        nbr_x      = '0;
        nbr_y      = '0;
        nbr_z      = '0;
        nbr_radius = '0;
        skip_entry = 1'b0;
        last_entry = 1'b0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        cell_x = '0;
        cell_y = '0;
        cell_z = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: cell in the middle, excess register bits set
        program_cell(32'hFF80_0000, 32'hAA80_0000, 32'h5580_0000, 32'hFFF8_0000);
        send_nbr('{x: POS_MAX, y: POS_MAX, z: POS_MAX, r: RAD_MAX, skip: 1'b1, last: 1'b0});
        send_nbr('{x: cell_x, y: cell_y, z: cell_z, r: RAD_MAX, skip: 1'b0, last: 1'b0});
        send_nbr('{x: cell_x - 24'h1000, y: cell_y, z: cell_z, r: 20'h8_0000,
                   skip: 1'b0, last: 1'b0});
        send_nbr('{x: cell_x, y: cell_y + 24'h3000, z: cell_z, r: 20'h1000,
                   skip: 1'b0, last: 1'b0});
        send_nbr('{x: cell_x + 24'h123, y: cell_y - 24'h456, z: cell_z + 24'h789,
                   r: 20'h0, skip: 1'b0, last: 1'b1});
        send_nbr('{x: '0, y: '0, z: '0, r: RAD_MAX, skip: 1'b0, last: 1'b0});
        send_nbr('{x: POS_MAX, y: POS_MAX, z: POS_MAX, r: RAD_MAX, skip: 1'b0, last: 1'b0});
        send_nbr('{x: cell_x - 24'h1, y: cell_y - 24'h1, z: cell_z - 24'h1, r: RAD_MAX,
                   skip: 1'b1, last: 1'b1});
        send_nbr('{x: '0, y: '0, z: '0, r: '0, skip: 1'b0, last: 1'b1});
        drain();

        // cell at the origin, no radius
        program_cell(32'h0, 32'h0, 32'h0, 32'h0);
        send_nbr('{x: 24'h1, y: '0, z: '0, r: RAD_MAX, skip: 1'b0, last: 1'b0});
        send_nbr('{x: '0, y: '0, z: '0, r: RAD_MAX, skip: 1'b0, last: 1'b0});
        send_nbr('{x: 24'h800, y: 24'h800, z: 24'h800, r: 20'h2000, skip: 1'b0, last: 1'b1});
        drain();

        // cell in the far corner, largest radius
        program_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_nbr('{x: POS_MAX - 24'h4_0000, y: POS_MAX, z: POS_MAX - 24'h7, r: RAD_MAX,
                   skip: 1'b0, last: 1'b0});
        send_nbr('{x: '0, y: POS_MAX, z: POS_MAX, r: RAD_MAX, skip: 1'b0, last: 1'b1});
        drain();

        // a long back-to-back set pushing +x and -y at full strength
        program_cell(32'h40_0000, 32'h40_0000, 32'h40_0000, 32'hF_FFFF);
        no_idle = 1'b1;
        for (int i = 0; i < 80; i++)
            send_nbr('{x: cell_x - 24'h1, y: cell_y + 24'h1, z: cell_z, r: RAD_MAX,
                       skip: 1'b0, last: (i == 79)});
        no_idle = 1'b0;
        drain();

        // random phases over several cells
        for (int ph = 0; ph < 5; ph++)
        begin
            program_cell($urandom, $urandom, $urandom, $urandom);
            if (ph == 1) hold_req = 1'b1;
            if (ph == 3) no_idle = 1'b1;
            random_sets(45);
            no_idle = 1'b0;
            random_sets(45);
            drain();
        end

        if (sb.failures == 0)
            $display("PASS overlap_repulsion_accumulate");
        else
            $display("FAIL overlap_repulsion_accumulate");
        $finish;
    end

endmodule
